### hw/rtl/fanmon_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the fan status monitor.
// No dependencies; imported by fanmon_eval and fan_status_monitor.
package fanmon_pkg;

  localparam int unsigned SpeedW   = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned PercentW = 7;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgAddrW = 3;

  localparam logic [SpeedW-1:0]   SpeedHyst  = 16'd50;
  localparam int unsigned         RoundHalf  = 5;
  localparam int unsigned         DutyDiv    = 10;
  localparam logic [PercentW-1:0] PercentMax = 7'd100;

  // Duty values at or above this limit round to a full 100 percent.
  localparam logic [15:0] DutySatLimit = 16'(100 * DutyDiv - RoundHalf);
  // Division by ten as a multiply by 205 and a shift by 11, exact below 1029.
  localparam logic [7:0]  DivTenRecip  = 8'd205;
  localparam int unsigned DivTenShift  = 11;

  localparam logic [CfgAddrW-1:0] AddrRunMinSpeed    = 3'd0;
  localparam logic [CfgAddrW-1:0] AddrStartupTimeout = 3'd4;

  typedef enum logic [1:0] {
    ST_OFF      = 2'd0,
    ST_STARTING = 2'd1,
    ST_RUNNING  = 2'd2,
    ST_ERROR    = 2'd3
  } fan_state_t;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_IDLE   = 3'd1,
    ACT_DETECT = 3'd2,
    ACT_ACCEL  = 3'd3,
    ACT_DECEL  = 3'd4,
    ACT_RAMP   = 3'd5
  } fan_action_t;

  typedef enum logic [1:0] {
    AL_NONE  = 2'd0,
    AL_WARN  = 2'd1,
    AL_FAULT = 2'd2
  } fan_alert_t;

  typedef struct packed {
    logic [15:0]       duty_permille;
    logic [SpeedW-1:0] measured_speed;
    logic [SpeedW-1:0] wanted_speed;
    logic              tach_present;
    logic [TimeW-1:0]  now_time;
    logic [TimeW-1:0]  command_time;
    logic              ramp_active;
  } sample_t;

  typedef struct packed {
    logic [SpeedW-1:0]   speed_out;
    logic [SpeedW-1:0]   target_out;
    logic [PercentW-1:0] duty_percent;
    fan_state_t          fan_state;
    fan_action_t         fan_action;
    fan_alert_t          fan_alert;
  } status_t;

  typedef struct packed {
    logic [SpeedW-1:0] running_min_speed;
    logic [TimeW-1:0]  startup_timeout;
  } cfg_t;

  typedef struct packed {
    logic [SpeedW-1:0] last_speed;
    logic              ever_detected;
  } track_t;

  function automatic logic [PercentW-1:0] duty_to_percent(input logic [15:0] duty);
    logic [9:0]  biased;
    logic [17:0] prod;
    biased = duty[9:0] + 10'(RoundHalf);
    prod   = 18'(biased) * 18'(DivTenRecip);
    if (duty >= DutySatLimit) begin
      return PercentMax;
    end
    return prod[DivTenShift +: PercentW];
  endfunction

endpackage

### hw/rtl/fan_status_monitor.sv
`timescale 1ns / 1ps
// Fan status monitor top level: sample register, classifier, result register
// and the configuration port. Depends on fanmon_pkg and fanmon_eval.
//
// Usage: each input transaction carries one fan update sample; each produces
// exactly one status transaction on the out_ channel, in order. A channel
// moves a transaction at a clock edge where its valid is high and its stall
// is low.
// A sample taken into the sample register is classified from it and shows
// on out_valid once the result register loads it. Throughput is one sample
// per cycle while out_stall is low, set by the single classification pass
// between the sample register and the result register, which also updates the
// stored last speed and the ever-detected flag.
// When out_stall is high the result register holds; one more sample may then
// wait in the sample register before in_stall rises.
// Reset (rst_n low, synchronous) empties both registers and clears the stored
// speed, the detection flag and both configuration registers.
// Configuration: running_min_speed at byte address 0, startup_timeout at 4;
// write only while no transaction is in flight.
module fan_status_monitor
  import fanmon_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_valid,
  output logic                in_stall,
  input  logic [15:0]         in_duty_permille,
  input  logic [SpeedW-1:0]   in_measured_speed,
  input  logic [SpeedW-1:0]   in_wanted_speed,
  input  logic                in_tach_present,
  input  logic [TimeW-1:0]    in_now_time,
  input  logic [TimeW-1:0]    in_command_time,
  input  logic                in_ramp_active,

  output logic                out_valid,
  input  logic                out_stall,
  output logic [SpeedW-1:0]   out_speed_out,
  output logic [SpeedW-1:0]   out_target_out,
  output logic [PercentW-1:0] out_duty_percent,
  output logic [1:0]          out_fan_state,
  output logic [2:0]          out_fan_action,
  output logic [1:0]          out_fan_alert,

  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  sample_t smp_r;
  logic    smp_vld_r;
  status_t res_r;
  logic    res_vld_r;
  track_t  trk_r;
  track_t  trk_nxt;
  cfg_t    cfg_r;
  status_t status;
  logic    load_res;
  logic    load_smp;
  logic    cfg_wr;

  assign load_res = smp_vld_r && (!res_vld_r || !out_stall);
  assign load_smp = in_valid && !in_stall;
  assign in_stall = smp_vld_r && !load_res;

  fanmon_eval u_eval (
    .smp     (smp_r),
    .cfg     (cfg_r),
    .trk     (trk_r),
    .status  (status),
    .trk_nxt (trk_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
      trk_r     <= '0;
    end else begin
      if (load_smp) begin
        smp_vld_r <= 1'b1;
      end else if (load_res) begin
        smp_vld_r <= 1'b0;
      end
      if (load_res) begin
        res_vld_r <= 1'b1;
        trk_r     <= trk_nxt;
      end else if (!out_stall) begin
        res_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_smp) begin
      smp_r.duty_permille  <= in_duty_permille;
      smp_r.measured_speed <= in_measured_speed;
      smp_r.wanted_speed   <= in_wanted_speed;
      smp_r.tach_present   <= in_tach_present;
      smp_r.now_time       <= in_now_time;
      smp_r.command_time   <= in_command_time;
      smp_r.ramp_active    <= in_ramp_active;
    end
    if (load_res) begin
      res_r <= status;
    end
  end

  assign out_valid        = res_vld_r;
  assign out_speed_out    = res_r.speed_out;
  assign out_target_out   = res_r.target_out;
  assign out_duty_percent = res_r.duty_percent;
  assign out_fan_state    = res_r.fan_state;
  assign out_fan_action   = res_r.fan_action;
  assign out_fan_alert    = res_r.fan_alert;

  // Only address bit 2 selects a register; the low bits are not decoded.
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        AddrRunMinSpeed[2]:    cfg_r.running_min_speed <= pwdata[SpeedW-1:0];
        AddrStartupTimeout[2]: cfg_r.startup_timeout   <= pwdata[TimeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      AddrRunMinSpeed[2]:    prdata = CfgDataW'(cfg_r.running_min_speed);
      AddrStartupTimeout[2]: prdata = CfgDataW'(cfg_r.startup_timeout);
      default:               prdata = '0;
    endcase
  end

  a_off_is_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld_r && (res_r.fan_state == ST_OFF)) |->
      ((res_r.speed_out == '0) && (res_r.fan_action == ACT_NONE) &&
       (res_r.fan_alert == AL_NONE) && (res_r.duty_percent == '0)))
    else $error("off status carries nonzero fields");

  a_alert_only_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld_r |-> ((res_r.fan_alert != AL_NONE) == (res_r.fan_state == ST_ERROR)))
    else $error("alert does not match error state");

  a_detect_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    trk_r.ever_detected |=> trk_r.ever_detected)
    else $error("detection flag cleared without reset");

  a_fault_needs_detect: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld_r && (res_r.fan_alert == AL_FAULT)) |-> trk_r.ever_detected)
    else $error("fault raised before any detection");

  a_percent_range: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld_r |-> (res_r.duty_percent <= PercentMax))
    else $error("duty percent above saturation");

endmodule

### hw/rtl/fanmon_eval.sv
`timescale 1ns / 1ps
// Combinational classification of one fan sample against the tracked speed.
// Depends on fanmon_pkg.
module fanmon_eval
  import fanmon_pkg::*;
(
  input  sample_t smp,
  input  cfg_t    cfg,
  input  track_t  trk,
  output status_t status,
  output track_t  trk_nxt
);

  logic              fan_on;
  logic              running;
  logic              in_window;
  logic [SpeedW-1:0] up_limit;
  logic [SpeedW-1:0] dn_level;
  logic [TimeW-1:0]  elapsed;

  always_comb begin
    fan_on    = (smp.duty_permille != '0);
    running   = smp.tach_present && (smp.measured_speed >= cfg.running_min_speed);
    // Both hysteresis sums wrap at 16 bits.
    up_limit  = trk.last_speed + SpeedHyst;
    dn_level  = smp.measured_speed + SpeedHyst;
    elapsed   = smp.now_time - smp.command_time;
    in_window = (elapsed <= cfg.startup_timeout);

    status.speed_out    = smp.measured_speed;
    status.target_out   = smp.wanted_speed;
    status.duty_percent = duty_to_percent(smp.duty_permille);
    status.fan_alert    = AL_NONE;
    status.fan_action   = ACT_DETECT;
    status.fan_state    = ST_ERROR;
    trk_nxt.last_speed    = smp.measured_speed;
    trk_nxt.ever_detected = trk.ever_detected;

    if (!fan_on) begin
      status.speed_out    = '0;
      status.target_out   = '0;
      status.duty_percent = '0;
      status.fan_state    = ST_OFF;
      status.fan_action   = ACT_NONE;
      trk_nxt.last_speed  = '0;
    end else if (running) begin
      status.fan_state      = ST_RUNNING;
      trk_nxt.ever_detected = 1'b1;
      if (smp.measured_speed > up_limit) begin
        status.fan_action = smp.ramp_active ? ACT_RAMP : ACT_ACCEL;
      end else if ((trk.last_speed > SpeedHyst) && (dn_level < trk.last_speed)) begin
        status.fan_action = ACT_DECEL;
      end else begin
        status.fan_action = ACT_IDLE;
      end
    end else if (in_window) begin
      status.fan_state = ST_STARTING;
    end else begin
      status.fan_alert = trk.ever_detected ? AL_FAULT : AL_WARN;
    end
  end

endmodule

### bench/fan_status_monitor_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for fan_status_monitor: directed and random fan samples,
// with random idling on both channels. Depends on fanmon_pkg and the block itself.
module fan_status_monitor_tb
  import fanmon_pkg::*;
();

  localparam int unsigned IdleLimit = 2000;

  // Predicts one status per accepted sample and checks the results in order.
  class fan_status_tracker;
    logic [SpeedW-1:0] min_speed;
    logic [TimeW-1:0]  timeout;
    logic [SpeedW-1:0] last_speed;
    bit                ever_seen;
    status_t           status_due[$];
    int unsigned       mismatches;

    function new();
      min_speed  = '0;
      timeout    = '0;
      last_speed = '0;
      ever_seen  = 1'b0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return status_due.size();
    endfunction

    function void note_sample(sample_t s);
      status_t          r;
      int unsigned      pct;
      logic [SpeedW-1:0] up;
      logic [SpeedW-1:0] dn;
      logic [TimeW-1:0]  elapsed;
      pct = (32'(s.duty_permille) + RoundHalf) / DutyDiv;
      r.duty_percent = (pct > 32'(PercentMax)) ? PercentMax : pct[PercentW-1:0];
      r.speed_out    = s.measured_speed;
      r.target_out   = s.wanted_speed;
      r.fan_alert    = AL_NONE;
      elapsed        = s.now_time - s.command_time;
      if (s.duty_permille == '0) begin
        r.fan_state  = ST_OFF;
        r.fan_action = ACT_NONE;
        r.speed_out  = '0;
        r.target_out = '0;
        last_speed   = '0;
      end else begin
        if (s.tach_present && s.measured_speed >= min_speed) begin
          // Both hysteresis sums wrap at 16 bits.
          up = last_speed + SpeedHyst;
          dn = s.measured_speed + SpeedHyst;
          r.fan_state = ST_RUNNING;
          ever_seen   = 1'b1;
          if (s.measured_speed > up) begin
            r.fan_action = s.ramp_active ? ACT_RAMP : ACT_ACCEL;
          end else if (last_speed > SpeedHyst && dn < last_speed) begin
            r.fan_action = ACT_DECEL;
          end else begin
            r.fan_action = ACT_IDLE;
          end
        end else if (elapsed <= timeout) begin
          r.fan_state  = ST_STARTING;
          r.fan_action = ACT_DETECT;
        end else begin
          r.fan_state  = ST_ERROR;
          r.fan_action = ACT_DETECT;
          r.fan_alert  = ever_seen ? AL_FAULT : AL_WARN;
        end
        last_speed = s.measured_speed;
      end
      status_due.push_back(r);
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_status(status_t got);
      status_t want;
      if (status_due.size() == 0) begin
        mismatches++;
        $display("%0t: status transaction with none outstanding, actual %p", $time, got);
        return;
      end
      want = status_due.pop_front();
      compare("speed_out", want.speed_out, got.speed_out);
      compare("target_out", want.target_out, got.target_out);
      compare("duty_percent", want.duty_percent, got.duty_percent);
      compare("fan_state", want.fan_state, got.fan_state);
      compare("fan_action", want.fan_action, got.fan_action);
      compare("fan_alert", want.fan_alert, got.fan_alert);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [15:0]         in_duty_permille = '0;
  logic [SpeedW-1:0]   in_measured_speed = '0;
  logic [SpeedW-1:0]   in_wanted_speed = '0;
  logic                in_tach_present = 1'b0;
  logic [TimeW-1:0]    in_now_time = '0;
  logic [TimeW-1:0]    in_command_time = '0;
  logic                in_ramp_active = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [SpeedW-1:0]   out_speed_out;
  logic [SpeedW-1:0]   out_target_out;
  logic [PercentW-1:0] out_duty_percent;
  logic [1:0]          out_fan_state;
  logic [2:0]          out_fan_action;
  logic [1:0]          out_fan_alert;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [CfgDataW-1:0] pwdata = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  fan_status_tracker tracker = new();
  bit                calm = 1'b0;
  int unsigned       stall_left = 0;
  int unsigned       idle_cycles = 0;

  fan_status_monitor u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_duty_permille  (in_duty_permille),
    .in_measured_speed (in_measured_speed),
    .in_wanted_speed   (in_wanted_speed),
    .in_tach_present   (in_tach_present),
    .in_now_time       (in_now_time),
    .in_command_time   (in_command_time),
    .in_ramp_active    (in_ramp_active),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_speed_out     (out_speed_out),
    .out_target_out    (out_target_out),
    .out_duty_percent  (out_duty_percent),
    .out_fan_state     (out_fan_state),
    .out_fan_action    (out_fan_action),
    .out_fan_alert     (out_fan_alert),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #5 clk = ~clk;

  // Result side: random stall bursts, none while calm.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 17) - 1;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    status_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.speed_out    = out_speed_out;
      got.target_out   = out_target_out;
      got.duty_percent = out_duty_percent;
      got.fan_state    = fan_state_t'(out_fan_state);
      got.fan_action   = fan_action_t'(out_fan_action);
      got.fan_alert    = fan_alert_t'(out_fan_alert);
      tracker.check_status(got);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic sample_t sample_of(logic [15:0] duty, logic [15:0] meas,
                                        logic [15:0] want, logic tach,
                                        logic [31:0] now_ms, logic [31:0] cmd_ms,
                                        logic ramp);
    sample_t s;
    s.duty_permille  = duty;
    s.measured_speed = meas;
    s.wanted_speed   = want;
    s.tach_present   = tach;
    s.now_time       = now_ms;
    s.command_time   = cmd_ms;
    s.ramp_active    = ramp;
    return s;
  endfunction

  // Mostly plausible samples: speeds near the last one or the running threshold,
  // elapsed times around the startup timeout; the rest is fully random.
  function automatic sample_t random_sample();
    sample_t     s;
    logic [31:0] elapsed;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) s.duty_permille = '0;
    else if (pick == 1) s.duty_permille = 16'($urandom_range(1, 20));
    else if (pick == 2) s.duty_permille = 16'($urandom_range(990, 1010));
    else if (pick <= 5) s.duty_permille = 16'($urandom_range(100, 1000));
    else s.duty_permille = 16'($urandom);
    pick = $urandom_range(0, 9);
    if (pick <= 3) begin
      s.measured_speed = tracker.last_speed + 16'($urandom_range(0, 240)) - 16'd120;
    end else if (pick <= 5) begin
      s.measured_speed = tracker.min_speed + 16'($urandom_range(0, 6)) - 16'd3;
    end else begin
      s.measured_speed = 16'($urandom);
    end
    s.wanted_speed = 16'($urandom);
    s.tach_present = ($urandom_range(0, 3) != 0);
    s.ramp_active  = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 9);
    if (pick <= 4) begin
      elapsed = tracker.timeout + 32'($urandom_range(0, 2)) - 32'd1;
    end else if (pick <= 6) begin
      elapsed = 32'(64'($urandom) % (64'(tracker.timeout) + 64'd1));
    end else begin
      elapsed = $urandom;
    end
    s.command_time = $urandom;
    s.now_time     = s.command_time + elapsed;
    return s;
  endfunction

  // Called and returns at a falling edge.
  task automatic send_sample(input sample_t s);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_duty_permille  <= s.duty_permille;
    in_measured_speed <= s.measured_speed;
    in_wanted_speed   <= s.wanted_speed;
    in_tach_present   <= s.tach_present;
    in_now_time       <= s.now_time;
    in_command_time   <= s.command_time;
    in_ramp_active    <= s.ramp_active;
    do @(posedge clk); while (in_stall);
    tracker.note_sample(s);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write one register, then read it back.
  task automatic cfg_write(input logic [CfgAddrW-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== data) begin
      tracker.mismatches++;
      $display("%0t: readback at address %0d mismatch, expected %h, actual %h",
               $time, addr, data, prdata);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_limits(input logic [15:0] min_rpm, input logic [31:0] timeout_ms);
    wait_drained();
    cfg_write(AddrRunMinSpeed, {16'd0, min_rpm});
    cfg_write(AddrStartupTimeout, timeout_ms);
    tracker.min_speed = min_rpm;
    tracker.timeout   = timeout_ms;
  endtask

  task automatic run_random(input int unsigned count);
    repeat (count) send_sample(random_sample());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Limits at their reset values: warn before any detection, zero-length window.
    send_sample(sample_of(16'd500, 16'd0, 16'd800, 1'b0, 32'd100, 32'd0, 1'b0));
    send_sample(sample_of(16'd500, 16'd0, 16'd800, 1'b0, 32'd7, 32'd7, 1'b0));
    send_sample(sample_of(16'd0, 16'd300, 16'd800, 1'b1, 32'd9, 32'd0, 1'b0));

    set_limits(16'd1000, 32'd500);
    // Window edges with tach present below the running threshold.
    send_sample(sample_of(16'd1, 16'd999, 16'd1200, 1'b1, 32'd1500, 32'd1000, 1'b0));
    send_sample(sample_of(16'd4, 16'd999, 16'd1200, 1'b1, 32'd1501, 32'd1000, 1'b0));
    // Running: idle, accel, ramp, decel, idle, with the duty rounding edges.
    send_sample(sample_of(16'd5, 16'd1000, 16'd1200, 1'b1, 32'd0, 32'd0, 1'b0));
    send_sample(sample_of(16'd994, 16'd1100, 16'd1200, 1'b1, 32'd0, 32'd0, 1'b0));
    send_sample(sample_of(16'd995, 16'd1200, 16'd1200, 1'b1, 32'd0, 32'd0, 1'b1));
    send_sample(sample_of(16'd999, 16'd1100, 16'd1200, 1'b1, 32'd0, 32'd0, 1'b1));
    send_sample(sample_of(16'd1000, 16'd1050, 16'd1200, 1'b1, 32'd0, 32'd0, 1'b0));
    // Elapsed time wraps through zero and is still inside the window.
    send_sample(sample_of(16'hFFFF, 16'd0, 16'hFFFF, 1'b0, 32'd5, 32'hFFFF_FFF0, 1'b0));
    // Timed out after an earlier detection gives a fault.
    send_sample(sample_of(16'd300, 16'd10, 16'd0, 1'b1, 32'd2000, 32'd1000, 1'b0));
    // Hysteresis sums that wrap at 16 bits.
    send_sample(sample_of(16'd600, 16'd65480, 16'd65535, 1'b1, 32'd0, 32'd0, 1'b0));
    send_sample(sample_of(16'd600, 16'd65500, 16'd65535, 1'b1, 32'd0, 32'd0, 1'b0));
    send_sample(sample_of(16'd600, 16'd65535, 16'd65535, 1'b1, 32'd0, 32'd0, 1'b1));
    send_sample(sample_of(16'd600, 16'd65535, 16'd65535, 1'b1, 32'd0, 32'd0, 1'b0));
    // Off with every other field at its maximum keeps the detection flag.
    send_sample(sample_of(16'd0, 16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 1'b1));
    send_sample(sample_of(16'd10, 16'd0, 16'd100, 1'b0, 32'd41, 32'd42, 1'b0));
    send_sample(sample_of(16'd20, 16'd0, 16'hFFFF, 1'b1, 32'd3, 32'd3, 1'b0));

    set_limits(16'd0, 32'd0);
    run_random(170);
    set_limits(16'hFFFF, 32'hFFFF_FFFF);
    run_random(170);
    set_limits(16'($urandom_range(0, 3000)), $urandom_range(0, 100000));
    run_random(170);
    set_limits(16'($urandom), $urandom);
    run_random(170);
    set_limits(16'd1500, 32'd1000);
    calm = 1'b1;
    run_random(170);

    wait_drained();
    repeat (10) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
